/* sv/lpp_pkg.sv */
// Shared types, constants and the CORDIC angle table for the lidar projection core.
package lpp_pkg;

  localparam int unsigned CordicStagesDef = 20;
  localparam int unsigned CoordW = 20;
  localparam int unsigned AngW = 24;
  localparam int unsigned CordW = 44;
  localparam int unsigned SqW = 41;
  localparam int unsigned RootW = 21;
  localparam logic signed [AngW-1:0] PiQ20 = 24'sd3294199;

  localparam logic [2:0] RegHeight = 3'd0;
  localparam logic [2:0] RegWidth  = 3'd1;
  localparam logic [2:0] RegTop    = 3'd2;
  localparam logic [2:0] RegRows   = 3'd3;
  localparam logic [2:0] RegCols   = 3'd4;

  function automatic logic [AngW-1:0] atan_q20(input int unsigned i);
    logic [AngW-1:0] v;
    case (i)
      0: v = 24'd823550;  1: v = 24'd486170;  2: v = 24'd256879;
      3: v = 24'd130396;  4: v = 24'd65451;   5: v = 24'd32757;
      6: v = 24'd16383;   7: v = 24'd8192;    8: v = 24'd4096;
      9: v = 24'd2048;    10: v = 24'd1024;   11: v = 24'd512;
      12: v = 24'd256;    13: v = 24'd128;    14: v = 24'd64;
      15: v = 24'd32;     16: v = 24'd16;     17: v = 24'd8;
      18: v = 24'd4;      19: v = 24'd2;      20: v = 24'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One CORDIC lane: vector, accumulated angle.
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  ang;
  } cord_t;

  // Point payload carried alongside the computation.
  typedef struct packed {
    logic               ok;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } side_t;

endpackage

/* sv/lpp_sqrt_cell.sv */
// One restoring square-root step cell, registered.
module lpp_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                     clk,
  input  logic                     vin,
  input  logic [lpp_pkg::SqW-1:0]  rem_in,
  input  logic [lpp_pkg::RootW-1:0] root_in,
  input  lpp_pkg::side_t           side_in,
  output logic                     vout,
  output logic [lpp_pkg::SqW-1:0]  rem_out,
  output logic [lpp_pkg::RootW-1:0] root_out,
  output lpp_pkg::side_t           side_out,
  input  logic                     rst_n
);
  import lpp_pkg::*;
  localparam int unsigned B = RootW - 1 - STEP;
  logic [SqW+1:0] trial;
  logic [SqW-1:0] rem_nxt;
  logic [RootW-1:0] root_nxt;
  logic vout_r;

  always_comb begin
    trial = ({2'b0, root_in} << (B + 1)) | ({{(SqW+1){1'b0}}, 1'b1} << (2 * B));
    if ({2'b0, rem_in} >= trial) begin
      rem_nxt = rem_in - trial[SqW-1:0];
      root_nxt = root_in | (RootW'(1) << B);
    end else begin
      rem_nxt = rem_in;
      root_nxt = root_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vout_r <= 1'b0;
    else vout_r <= vin;
    rem_out <= rem_nxt;
    root_out <= root_nxt;
    side_out <= side_in;
  end
  assign vout = vout_r;
endmodule

/* sv/lpp_cordic_cell.sv */
// One CORDIC vectoring micro-rotation cell for two lanes, registered.
module lpp_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vin,
  input  lpp_pkg::cord_t a_in,
  input  lpp_pkg::cord_t b_in,
  input  lpp_pkg::side_t side_in,
  output logic          vout,
  output lpp_pkg::cord_t a_out,
  output lpp_pkg::cord_t b_out,
  output lpp_pkg::side_t side_out
);
  import lpp_pkg::*;
  logic vout_r;

  function automatic cord_t rot(input cord_t c);
    cord_t o;
    logic signed [AngW-1:0] t;
    t = atan_q20(STEP);
    if (c.y >= 0) begin
      o.x = c.x + (c.y >>> STEP);
      o.y = c.y - (c.x >>> STEP);
      o.ang = c.ang + t;
    end else begin
      o.x = c.x - (c.y >>> STEP);
      o.y = c.y + (c.x >>> STEP);
      o.ang = c.ang - t;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) vout_r <= 1'b0;
    else vout_r <= vin;
    a_out <= rot(a_in);
    b_out <= rot(b_in);
    side_out <= side_in;
  end
  assign vout = vout_r;
endmodule

/* sv/lidar_point_to_pixel_projection_core.sv */
// Top level of the lidar point to range-image pixel projection core.
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tdata: pos_x, pos_y, pos_z, range_mm
//  out_    | out | out_tvalid/out_tready | tdata: pixel_row, pixel_col, in_image
//  cfg_    | in  | cfg_we                | cfg_index, cfg_data
// One point per cycle while in_tready is high; 21 sqrt cells then CORDIC_STAGES CORDIC cells.
// The sqrt and CORDIC cell chains set the latency; the squaring and scale multipliers a stage each.
// Reset is synchronous; the pipeline valid bits clear and config registers take defaults.
// The cells run freely; input is refused once results in flight plus buffered
// results fill the result buffer, so a stalled output never drops a transaction.
module lidar_point_to_pixel_projection_core #(
  parameter int unsigned CORDIC_STAGES = lpp_pkg::CordicStagesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // pos_x, pos_y, pos_z, range_mm (low bit up)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // pixel_row, pixel_col, in_image (low bit up)
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import lpp_pkg::*;

  logic [7:0]  hgt_r;
  logic [12:0] wid_r;
  logic [20:0] top_r;
  logic [23:0] rpr_r, cpr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hgt_r <= 8'd64; wid_r <= 13'd1024; top_r <= 21'd183000;
      rpr_r <= 24'd1000000; cpr_r <= 24'd667625;
    end else if (cfg_we) begin
      case (cfg_index)
        RegHeight: hgt_r <= cfg_data[7:0];
        RegWidth:  wid_r <= cfg_data[12:0];
        RegTop:    top_r <= cfg_data[20:0];
        RegRows:   rpr_r <= cfg_data;
        RegCols:   cpr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stall handling: the cells are free-running, so gate input by output space.
  // The result FIFO below absorbs results while the output stalls; the core
  // refuses input unless every in-flight result has room in that FIFO.
  localparam int unsigned Lat = 2 + RootW + CORDIC_STAGES + 3;
  localparam int unsigned FifoD = Lat + 2;
  localparam int unsigned CntW = $clog2(FifoD + 1);
  localparam int unsigned PtrW = $clog2(FifoD);

  logic [CntW-1:0] credit_r, credit_nxt;
  logic res_v;
  logic [21:0] res_d;
  logic out_take, in_take;
  assign in_take = in_tvalid && in_tready;
  assign out_take = out_tvalid && out_tready;
  // Credit counts results in flight plus buffered.
  assign in_tready = credit_r < CntW'(FifoD);
  always_comb begin
    credit_nxt = credit_r;
    if (in_take && !out_take) credit_nxt = credit_r + 1'b1;
    else if (!in_take && out_take) credit_nxt = credit_r - 1'b1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) credit_r <= '0;
    else credit_r <= credit_nxt;
  end

  // Stage 0: unpack, range test, |z|; stage 1: r^2 - z^2.
  logic signed [CoordW-1:0] ix, iy, iz;
  logic [19:0] ir, iaz;
  assign ix = in_tdata[19:0];
  assign iy = in_tdata[39:20];
  assign iz = in_tdata[59:40];
  assign ir = in_tdata[79:60];
  assign iaz = iz[19] ? 20'(-iz) : iz;

  logic s0_v_r;
  side_t s0_side_r;
  logic [19:0] s0_r_r, s0_az_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else s0_v_r <= in_take;
    s0_side_r <= '{ok: (ir != 0) && (ir >= iaz), x: ix, y: iy, z: iz};
    s0_r_r <= ir; s0_az_r <= iaz;
  end
  logic s1_v_r;
  side_t s1_side_r;
  logic [SqW-1:0] s1_sq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= s0_v_r;
    s1_side_r <= s0_side_r;
    s1_sq_r <= s0_r_r * s0_r_r - s0_az_r * s0_az_r;
  end

  // Square-root cell chain.
  logic [RootW:0] sv_v;
  logic [SqW-1:0] s_rem [RootW+1];
  logic [RootW-1:0] s_root [RootW+1];
  side_t s_side [RootW+1];
  assign sv_v[0] = s1_v_r;
  assign s_rem[0] = s1_sq_r;
  assign s_root[0] = '0;
  assign s_side[0] = s1_side_r;
  for (genvar g = 0; g < RootW; g++) begin : g_sq
    lpp_sqrt_cell #(.STEP(g)) u_cell (
      .clk, .rst_n, .vin(sv_v[g]), .rem_in(s_rem[g]), .root_in(s_root[g]),
      .side_in(s_side[g]), .vout(sv_v[g+1]), .rem_out(s_rem[g+1]),
      .root_out(s_root[g+1]), .side_out(s_side[g+1]));
  end

  // Prefold both CORDIC inputs into the right half-plane.
  function automatic cord_t prep(input logic signed [CoordW+1:0] y,
                                 input logic signed [CoordW+1:0] x);
    cord_t c;
    logic signed [CoordW+1:0] xx, yy;
    c.ang = '0; xx = x; yy = y;
    if (x < 0) begin
      c.ang = (y >= 0) ? PiQ20 : -PiQ20;
      xx = -x; yy = -y;
    end
    c.x = CordW'(xx) <<< 20;
    c.y = CordW'(yy) <<< 20;
    return c;
  endfunction

  logic [CORDIC_STAGES:0] cv;
  cord_t ca [CORDIC_STAGES+1];
  cord_t cb [CORDIC_STAGES+1];
  side_t cs [CORDIC_STAGES+1];
  assign cv[0] = sv_v[RootW];
  assign ca[0] = prep(22'(s_side[RootW].z), 22'({1'b0, s_root[RootW]}));
  assign cb[0] = prep(22'(s_side[RootW].y), -22'(s_side[RootW].x));
  assign cs[0] = s_side[RootW];
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cd
    lpp_cordic_cell #(.STEP(g)) u_cell (
      .clk, .rst_n, .vin(cv[g]), .a_in(ca[g]), .b_in(cb[g]), .side_in(cs[g]),
      .vout(cv[g+1]), .a_out(ca[g+1]), .b_out(cb[g+1]), .side_out(cs[g+1]));
  end

  // Scale stage: angle times rate.
  logic m_v_r, m_ok_r;
  logic signed [48:0] m_p_r;
  logic signed [48:0] m_q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else m_v_r <= cv[CORDIC_STAGES];
    m_ok_r <= cs[CORDIC_STAGES].ok;
    m_p_r <= (25'(signed'({1'b0, top_r})) - 25'(ca[CORDIC_STAGES].ang))
             * signed'({1'b0, rpr_r});
    m_q_r <= (25'(cb[CORDIC_STAGES].ang) + 25'(PiQ20)) * signed'({1'b0, cpr_r});
  end

  // Row rounding, column truncation and bounds.
  logic signed [48:0] pabs, qabs;
  logic signed [17:0] rowv, colv;
  logic [8:0] hc;
  logic [13:0] wc;
  logic okf;
  always_comb begin
    pabs = m_p_r[48] ? -m_p_r : m_p_r;
    rowv = 18'((pabs + 49'sd2147483648) >>> 32);
    if (m_p_r[48]) rowv = -rowv;
    qabs = m_q_r[48] ? -m_q_r : m_q_r;
    colv = 18'(qabs >>> 32);
    if (m_q_r[48]) colv = -colv;
    hc = (hgt_r > 8'd128) ? 9'd128 : {1'b0, hgt_r};
    wc = (wid_r > 13'd4096) ? 14'd4096 : {1'b0, wid_r};
    okf = m_ok_r && !rowv[17] && (rowv < 18'(hc)) && !colv[17] && (colv < 18'(wc));
  end
  assign res_v = m_v_r;
  assign res_d = okf ? {1'b1, colv[12:0], rowv[7:0]} : {1'b0, 13'h1FFF, 8'hFF};

  // Result FIFO with a registered output stage; refill it whenever it empties
  // or its transaction is taken.
  logic [21:0] mem [FifoD];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [CntW-1:0] fc_r;
  logic [21:0] od_r;
  logic ov_r;
  logic pop;
  assign pop = (fc_r != '0) && (!ov_r || out_take);
  always_ff @(posedge clk) begin
    if (res_v) mem[wp_r] <= res_d;
    if (pop) od_r <= mem[rp_r];
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; fc_r <= '0; ov_r <= 1'b0;
    end else begin
      if (res_v) wp_r <= (wp_r == PtrW'(FifoD - 1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == PtrW'(FifoD - 1)) ? '0 : rp_r + 1'b1;
      fc_r <= fc_r + CntW'(res_v) - CntW'(pop);
      if (pop) ov_r <= 1'b1;
      else if (out_take) ov_r <= 1'b0;
    end
  end
  assign out_tvalid = ov_r;
  assign out_tdata = {2'b0, od_r};

`ifndef SYNTHESIS
  a_fifo_le_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= credit_r) else $error("buffered results exceed credits");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CntW'(FifoD)) else $error("result buffer overflow");
  a_credit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_take && !out_take |=> credit_r == $past(credit_r))
    else $error("credit drift");
`endif
endmodule

/* tb/sv/tb_top.sv */
// Testbench for the lidar point to range-image pixel projection core.
`timescale 1ns / 1ps

module tb_top;
  import lpp_pkg::*;

  localparam int CordStages = 20;
  localparam int PipeLat = 2 + 21 + CordStages + 3;
  localparam int DirectedPts = 24;
  localparam int RandomPts = 1650;
  localparam longint PiFix = 3294199;
  localparam longint HalfQ32 = 64'sd1 << 31;

  // One lidar point as it enters the core.
  typedef struct {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] pz;
    logic [19:0]        rng;
  } point_t;

  // One pixel result.
  typedef struct {
    logic signed [7:0]  row;
    logic signed [12:0] col;
    logic               hit;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // pos_x, pos_y, pos_z, range_mm (lowest bit up)
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // pixel_row, pixel_col, in_image (lowest bit up)
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  // Shadow copy of the core's registers.
  longint img_h, img_w, top_elev, rows_rate, cols_rate;

  point_t pending_pts[$];
  pixel_t expected_pixels[$];
  int     err_count;
  longint cycle_count;
  int     send_gap;
  int     take_gap;
  bit     gaps_on;

  lidar_point_to_pixel_projection_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint fsr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring-mode arctangent in Q20 radians.
  function automatic longint vec_angle(longint y, longint x);
    longint ang, dx, dy;
    ang = 0;
    if (x < 0) begin
      ang = (y >= 0) ? PiFix : -PiFix;
      x = -x;
      y = -y;
    end
    x = x * (64'sd1 <<< 20);
    y = y * (64'sd1 <<< 20);
    for (int i = 0; i < CordStages; i++) begin
      dx = fsr(y, i);
      dy = fsr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; ang += longint'(atan_q20(i));
      end else begin
        x -= dx; y += dy; ang -= longint'(atan_q20(i));
      end
    end
    return ang;
  endfunction

  function automatic pixel_t project_point(point_t pt);
    pixel_t pix;
    longint x, y, z, r, az, hgt, wid, c, elev, p, row, col, azim;
    bit ok;
    x = pt.px; y = pt.py; z = pt.pz; r = longint'(pt.rng);
    az = z < 0 ? -z : z;
    hgt = img_h > 128 ? 128 : img_h;
    wid = img_w > 4096 ? 4096 : img_w;
    ok = 0;
    row = -1;
    col = -1;
    if (r != 0 && r >= az) begin
      c = int_sqrt(r * r - z * z);
      elev = vec_angle(z, c);
      p = (top_elev - elev) * rows_rate;
      row = p >= 0 ? (p + HalfQ32) / (64'sd1 <<< 32) : -((-p + HalfQ32) / (64'sd1 <<< 32));
      if (row >= 0 && row < hgt) begin
        azim = vec_angle(y, -x) + PiFix;
        col = (azim * cols_rate) / (64'sd1 <<< 32);
        if (col >= 0 && col < wid) ok = 1;
      end
    end
    if (!ok) begin
      row = -1;
      col = -1;
    end
    pix.row = row[7:0];
    pix.col = col[12:0];
    pix.hit = ok;
    return pix;
  endfunction

  // Driver: hold the current transaction until it is taken, then advance.
  always @(posedge clk) begin
    int gap;
    point_t pt;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap == 0 && pending_pts.size() > 0) begin
          pt = pending_pts.pop_front();
          expected_pixels.push_back(project_point(pt));
          in_tdata <= {pt.rng, pt.pz, pt.py, pt.px};
        end else begin
          in_tvalid <= 1'b0;
          send_gap <= (gap > 0) ? gap - 1 : 0;
        end
      end else if (!in_tvalid && send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (!in_tvalid && pending_pts.size() > 0) begin
        pt = pending_pts.pop_front();
        expected_pixels.push_back(project_point(pt));
        in_tdata <= {pt.rng, pt.pz, pt.py, pt.px};
        in_tvalid <= 1'b1;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation; stall ready at random.
  always @(posedge clk) begin
    int gap;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        pixel_t got, exp_pix;
        got.row = out_tdata[7:0];
        got.col = out_tdata[20:8];
        got.hit = out_tdata[21];
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel row %0d col %0d hit %0b", $time,
                   got.row, got.col, got.hit);
          err_count++;
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (got.row !== exp_pix.row || got.col !== exp_pix.col ||
              got.hit !== exp_pix.hit) begin
            $display("%0t: expected row %0d col %0d hit %0b, actual row %0d col %0d hit %0b",
                     $time, exp_pix.row, exp_pix.col, exp_pix.hit,
                     got.row, got.col, got.hit);
            err_count++;
          end
        end
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        take_gap <= (gap > 0) ? gap - 1 : 0;
        out_tready <= (gap == 0);
      end else if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegHeight: img_h = val & 64'hFF;
      RegWidth:  img_w = val & 64'h1FFF;
      RegTop:    top_elev = val & 64'h1FFFFF;
      RegRows:   rows_rate = val & 64'hFFFFFF;
      RegCols:   cols_rate = val & 64'hFFFFFF;
      default: ;
    endcase
  endtask

  // Wait for every expected pixel, then let the pipe run dry.
  task automatic drain();
    while (pending_pts.size() > 0 || in_tvalid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (PipeLat + 5) @(posedge clk);
  endtask

  function automatic logic signed [19:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 40000) - 20000;
      1: return 20'($urandom);
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom_range(0, 1) == 0 ? 20'($urandom_range(0, 100000))
                                                : -20'($urandom_range(0, 100000));
    endcase
  endfunction

  // Mostly geometrically consistent points; a quarter random range noise.
  task automatic queue_random(int n);
    point_t pt;
    longint s;
    for (int k = 0; k < n; k++) begin
      pt.px = rand_coord();
      pt.py = rand_coord();
      pt.pz = ($urandom_range(0, 3) == 0) ? rand_coord()
                                          : 20'(($urandom_range(0, 4000) - 2000));
      if ($urandom_range(0, 3) == 0) begin
        pt.rng = 20'($urandom);
      end else begin
        s = longint'(pt.px) * pt.px + longint'(pt.py) * pt.py + longint'(pt.pz) * pt.pz;
        s = int_sqrt(s);
        pt.rng = s > 1048575 ? 20'hFFFFF : 20'(s + $urandom_range(0, 2));
      end
      pending_pts.push_back(pt);
    end
  endtask

  task automatic queue_point(longint x, longint y, longint z, longint r);
    point_t pt;
    pt.px = x[19:0]; pt.py = y[19:0]; pt.pz = z[19:0]; pt.rng = r[19:0];
    pending_pts.push_back(pt);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegHeight;
    cfg_data = '0;
    err_count = 0;
    cycle_count = 0;
    send_gap = 0;
    take_gap = 0;
    gaps_on = 1'b0;
    img_h = 64; img_w = 1024; top_elev = 183000; rows_rate = 1000000; cols_rate = 667625;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, zero and short range, points on every axis.
    queue_point(10000, 0, 0, 10000);
    queue_point(-10000, 0, 0, 10000);
    queue_point(0, 10000, 0, 10000);
    queue_point(0, -10000, 0, 10000);
    queue_point(-10000, -1, 0, 10000);
    queue_point(1000, 1000, 100, 1419);
    queue_point(0, 0, 0, 0);
    queue_point(500, 500, 1000, 999);
    queue_point(0, 0, 1000, 1000);
    queue_point(0, 0, -1000, 1000);
    queue_point(-524288, -524288, -524288, 1048575);
    queue_point(524287, 524287, 524287, 1048575);
    queue_point(524287, -524288, 0, 1048575);
    queue_point(-524288, 524287, 0, 1048575);
    queue_point(3, 4, 0, 5);
    queue_point(-1, 0, 0, 1);
    queue_point(20000, 3000, -3000, 20445);
    queue_point(-20000, 3000, 3000, 20445);
    queue_point(1, 1, 524287, 524287);
    queue_point(1, 1, -524288, 524288);
    queue_point(0, 0, 0, 1048575);
    queue_point(100, -100, 0, 1);
    queue_point(-7000, -7000, 200, 9902);
    queue_point(7000, -7000, -200, 9902);
    drain();

    // Extremes of every register.
    write_reg(RegHeight, 255);
    write_reg(RegWidth, 8191);
    write_reg(RegTop, 1171269);
    write_reg(RegRows, 16777215);
    write_reg(RegCols, 16777215);
    queue_random(DirectedPts);
    drain();
    write_reg(RegHeight, 0);
    write_reg(RegWidth, 0);
    write_reg(RegTop, 0);
    write_reg(RegRows, 0);
    write_reg(RegCols, 0);
    queue_random(DirectedPts);
    drain();
    write_reg(RegHeight, 1);
    write_reg(RegWidth, 1);
    write_reg(RegRows, 1);
    write_reg(RegCols, 1);
    queue_random(DirectedPts);
    drain();
    write_reg(3'd7, 12345);  // unknown index: no effect expected

    // Random phases: several typical settings, with and without stalls.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(RegHeight, ph == 4 ? 128 : $urandom_range(16, 140));
      write_reg(RegWidth, ph == 4 ? 4096 : $urandom_range(256, 4200));
      write_reg(RegTop, $urandom_range(50000, 400000));
      write_reg(RegRows, $urandom_range(200000, 3000000));
      write_reg(RegCols, $urandom_range(100000, 3000000));
      gaps_on = (ph != 2);
      queue_random(RandomPts / 5);
      drain();
    end

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Run limit: far above the slowest correct run.
  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule
